[hdl/bdq_pkg.sv]
// Shared types and codes for the bounded double-ended queue.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bdq_pkg;

   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_READ       = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE = 2'd0,
      CTL_EXEC = 2'd1,
      CTL_RESP = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

   localparam int unsigned INDEX_W = 10;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 11;

endpackage

[hdl/bdq_ctrl.sv]
// Request sequencer for the bounded double-ended queue.
// Depends on bdq_pkg; drives the datapath command struct and the response strobe.
`timescale 1ns / 1ps

module bdq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output bdq_pkg::dp_cmd_type cmd
);
   import bdq_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            state_in = CTL_RESP;
         end
         CTL_RESP: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         CTL_EXEC: begin
            cmd.exec = 1'b1;
         end
         CTL_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[hdl/bdq_datapath.sv]
// Storage, pointers and status for the bounded double-ended queue.
// Depends on bdq_pkg; driven by the command struct from bdq_ctrl.
`timescale 1ns / 1ps

module bdq_datapath #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bdq_pkg::dp_cmd_type               cmd,
   input  logic [1:0]                        req_opcode,
   input  logic signed [bdq_pkg::VALUE_W-1:0] req_push_value,
   input  logic [bdq_pkg::INDEX_W-1:0]       req_read_index,
   output logic signed [bdq_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [1:0]                        rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]       rsp_element_count
);
   import bdq_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned XW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [VALUE_W-1:0] mem [DEPTH];

   opcode_type         op_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [AW-1:0]      head_ff;
   logic [AW-1:0]      head_in;
   logic [CW-1:0]      occ_ff;
   logic [CW-1:0]      occ_in;
   status_type         status_ff;
   status_type         status_in;
   logic               rd_ok_ff;
   logic               rd_ok_in;
   logic [VALUE_W-1:0] rdata_ff;

   logic               full;
   logic               in_range;
   logic [AW:0]        offset;
   logic [AW:0]        sum;
   logic [AW-1:0]      slot;
   logic [AW-1:0]      front_slot;
   logic [AW-1:0]      wr_slot;
   logic               wr_en;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= opcode_type'(req_opcode);
         val_ff <= req_push_value;
         idx_ff <= req_read_index;
      end
   end

   always_comb begin
      full       = (occ_ff == FULL_COUNT);
      in_range   = XW'(idx_ff) < XW'(occ_ff);
      offset     = (op_ff == OP_READ) ? (AW + 1)'(idx_ff) : (AW + 1)'(occ_ff);
      sum        = {1'b0, head_ff} + offset;
      slot       = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : sum[AW-1:0];
      front_slot = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
      wr_slot    = (op_ff == OP_PUSH_FRONT) ? front_slot : slot;

      head_in   = head_ff;
      occ_in    = occ_ff;
      status_in = STAT_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      case (op_ff)
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               wr_en  = 1'b1;
               occ_in = occ_ff + CW'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               wr_en   = 1'b1;
               head_in = front_slot;
               occ_in  = occ_ff + CW'(1);
            end
         end
         OP_READ: begin
            if (in_range) begin
               rd_ok_in = 1'b1;
            end else begin
               status_in = STAT_RANGE;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_slot] <= val_ff;
      end
      if (cmd.exec) begin
         rdata_ff <= mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         occ_ff    <= '0;
         status_ff <= STAT_OK;
         rd_ok_ff  <= 1'b0;
      end else if (cmd.exec) begin
         head_ff   <= head_in;
         occ_ff    <= occ_in;
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   assign rsp_read_value    = rd_ok_ff ? $signed(rdata_ff) : '0;
   assign rsp_status        = status_ff;
   assign rsp_element_count = COUNT_W'(occ_ff);

endmodule

[hdl/bounded_double_ended_queue_top.sv]
// Top level of the bounded double-ended queue: a circular store of signed words.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
`timescale 1ns / 1ps

// Usage:
//   Drive req_opcode, req_push_value and req_read_index with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   Opcodes: push at back, push at front, read by index from the front, none.
//   Each request yields one response, shown for exactly one cycle with
//   rsp_valid high: rsp_read_value (zero unless a read succeeded),
//   rsp_status (ok, push rejected because full, index out of range) and
//   rsp_element_count (count after the request, low 11 bits).
//   The response is driven once the execute step is done and is taken at
//   the edge that ends the response cycle.
//   A new request waits for the last response; busy stays high from the
//   accepting edge until the response cycle ends. The three steps are take,
//   execute (one store write or registered store read plus pointer update)
//   and respond.
//   Reset empties the queue at once; store contents need no clearing.
//   The receiver cannot stall: a response is gone after its one cycle.
module bounded_double_ended_queue_top #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_opcode,
   input  logic signed [bdq_pkg::VALUE_W-1:0] req_push_value,
   input  logic [bdq_pkg::INDEX_W-1:0]        req_read_index,
   output logic                               rsp_valid,
   output logic signed [bdq_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [1:0]                         rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]        rsp_element_count
);
   import bdq_pkg::*;

   dp_cmd_type cmd;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_push_value    (req_push_value),
      .req_read_index    (req_read_index),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

endmodule

[sim/bdq_reply_checker.sv]
// Response checker for the bounded double-ended queue: watches the request and
// response ports, predicts each response and compares it. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_reply_checker #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [1:0]                         req_opcode,
   input  logic signed [bdq_pkg::VALUE_W-1:0] req_push_value,
   input  logic [bdq_pkg::INDEX_W-1:0]        req_read_index,
   input  logic                               rsp_valid,
   input  logic signed [bdq_pkg::VALUE_W-1:0] rsp_read_value,
   input  logic [1:0]                         rsp_status,
   input  logic [bdq_pkg::COUNT_W-1:0]        rsp_element_count,
   output int                                 fail_count,
   output int                                 pending
);

   import bdq_pkg::*;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      status_type                status;
      logic [COUNT_W-1:0]        count;
   } deque_reply_type;

   logic [VALUE_W-1:0] word_store [DEPTH];
   int unsigned        front_slot;
   int unsigned        held;
   deque_reply_type    replies_due [$];

   function automatic deque_reply_type apply_request(opcode_type op, logic [VALUE_W-1:0] word,
                                                     logic [INDEX_W-1:0] idx);
      deque_reply_type r;
      r.value  = '0;
      r.status = STAT_OK;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (held >= DEPTH) begin
               r.status = STAT_FULL;
            end else if (op == OP_PUSH_BACK) begin
               word_store[(front_slot + held) % DEPTH] = word;
               held++;
            end else begin
               front_slot = (front_slot + DEPTH - 1) % DEPTH;
               word_store[front_slot] = word;
               held++;
            end
         end
         OP_READ: begin
            if (idx >= held) begin
               r.status = STAT_RANGE;
            end else begin
               r.value = word_store[(front_slot + idx) % DEPTH];
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(held);
      return r;
   endfunction

   function automatic int check_field(string name, longint want, longint got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      deque_reply_type got;
      deque_reply_type want;
      deque_reply_type fresh;
      int              errs;
      errs = 0;
      if (reset) begin
         front_slot = 0;
         held       = 0;
         replies_due.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         // match the response first: it always belongs to an older request
         if (rsp_valid) begin
            got.value  = rsp_read_value;
            got.status = status_type'(rsp_status);
            got.count  = rsp_element_count;
            if (replies_due.size() == 0) begin
               $display("%0t: response with no request outstanding, got value %0d status %0d count %0d",
                        $time, got.value, got.status, got.count);
               errs++;
            end else begin
               want = replies_due.pop_front();
               errs += check_field("read_value", longint'(want.value), longint'(got.value));
               errs += check_field("status", longint'(want.status), longint'(got.status));
               errs += check_field("element_count", longint'(want.count), longint'(got.count));
            end
         end
         if (start && !busy) begin
            fresh = apply_request(opcode_type'(req_opcode), req_push_value, req_read_index);
            replies_due.insert(replies_due.size(), fresh);
         end
         fail_count <= fail_count + errs;
         pending    <= replies_due.size();
      end
   end

endmodule

[sim/tb_top.sv]
// Testbench top for the bounded double-ended queue: drives requests with random
// gaps and gives the verdict. Depends on bdq_pkg, bdq_reply_checker and the RTL top.
`timescale 1ns / 1ps

module tb_top;

   import bdq_pkg::*;

   localparam int unsigned DEPTH      = 1024;
   localparam int unsigned IDLE_LIMIT = 2000;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      start          = 1'b0;
   logic [1:0]                req_opcode     = '0;
   logic signed [VALUE_W-1:0] req_push_value = '0;
   logic [INDEX_W-1:0]        req_read_index = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [1:0]                rsp_status;
   logic [COUNT_W-1:0]        rsp_element_count;
   int                        fail_count;
   int                        pending;
   int unsigned               queued     = 0;
   int unsigned               flat_run   = 0;
   int unsigned               idle_count = 0;

   bounded_double_ended_queue_top #(.DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_push_value    (req_push_value),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   bdq_reply_checker #(.DEPTH(DEPTH)) reply_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_push_value    (req_push_value),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("bounded_double_ended_queue_top test failed");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (flat_run > 0) begin
         flat_run--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         flat_run = $urandom_range(20, 40);
         return 0;
      end
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(opcode_type op, logic [VALUE_W-1:0] word,
                               logic [INDEX_W-1:0] idx);
      int unsigned gap;
      req_opcode     <= op;
      req_push_value <= word;
      req_read_index <= idx;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      if ((op == OP_PUSH_BACK || op == OP_PUSH_FRONT) && queued < DEPTH) queued++;
      gap = pick_gap();
      if (gap > 0) begin
         // drop start and scramble the idle request fields
         start          <= 1'b0;
         req_opcode     <= 2'($urandom);
         req_push_value <= $urandom;
         req_read_index <= INDEX_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_request(int unsigned push_pct);
      int unsigned        r;
      logic [VALUE_W-1:0] word;
      logic [INDEX_W-1:0] idx;
      r    = $urandom_range(0, 99);
      word = $urandom;
      idx  = INDEX_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: word = 32'h8000_0000;
            1: word = 32'h7fff_ffff;
            2: word = '1;
            default: word = '0;
         endcase
      end
      if (r < push_pct) begin
         send_request(r[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, word, idx);
      end else if (r < push_pct + 4) begin
         send_request(OP_NONE, word, idx);
      end else begin
         if (queued > 0 && $urandom_range(0, 4) != 0) begin
            idx = INDEX_W'($urandom_range(0, queued - 1));
         end else if (queued < DEPTH) begin
            idx = INDEX_W'($urandom_range(queued, DEPTH - 1));
         end
         send_request(OP_READ, word, idx);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: out-of-range reads, unused opcode, front push wrapping slot 0
      send_request(OP_READ, 32'h1234_5678, '0);
      send_request(OP_READ, '0, '1);
      send_request(OP_NONE, 32'hdead_beef, 10'h155);
      send_request(OP_PUSH_FRONT, 32'h8000_0000, '0);
      send_request(OP_PUSH_BACK, 32'h7fff_ffff, '1);
      send_request(OP_PUSH_FRONT, '1, 10'h2aa);
      send_request(OP_PUSH_BACK, '0, 10'h155);
      send_request(OP_READ, '1, 10'd0);
      send_request(OP_READ, '0, 10'd1);
      send_request(OP_READ, '0, 10'd2);
      send_request(OP_READ, '0, 10'd3);
      send_request(OP_READ, '0, 10'd4);
      send_request(OP_READ, '0, '1);
      send_request(OP_NONE, 32'h0f0f_0f0f, 10'd1);
      send_request(OP_PUSH_BACK, 32'h5555_5555, 10'h2aa);
      send_request(OP_PUSH_FRONT, 32'haaaa_aaaa, 10'h155);
      send_request(OP_READ, '0, 10'd0);
      send_request(OP_READ, '0, 10'd5);
      send_request(OP_READ, '0, 10'd6);

      repeat (60) random_request(40);
      while (queued < DEPTH) random_request(92);

      // full queue: rejected pushes and reads up to the last index
      send_request(OP_READ, '0, '1);
      send_request(OP_PUSH_BACK, 32'h7fff_ffff, '0);
      send_request(OP_PUSH_FRONT, 32'h8000_0000, '0);
      repeat (20) random_request(50);

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("bounded_double_ended_queue_top test passed");
      end else begin
         $display("bounded_double_ended_queue_top test failed");
      end
      $finish;
   end

endmodule
